@@ rtl/csl_pkg.sv @@
// Package for the circular sequence list: sizes, operation and status codes,
// sequencer states and the control bundle that drives the ring of cells.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package csl_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int ENT_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    F_APPEND    = 3'd0,
    F_INS_FRONT = 3'd1,
    F_INS_KEY   = 3'd2,
    F_REVERSE   = 3'd3,
    F_DEL_FRONT = 3'd4,
    F_DEL_END   = 3'd5,
    F_DEL_KEY   = 3'd6,
    F_READ      = 3'd7
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    S_OK        = 2'd0,
    S_EMPTY     = 2'd1,
    S_FULL      = 2'd2,
    S_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PASS = 4'b0010,
    ST_ROT  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_LEFT  = 2'd1,
    SH_RIGHT = 2'd2
  } shift_t;

  typedef struct packed {
    shift_t           shift;
    logic [VAL_W-1:0] emit;
  } ring_ctl_t;

endpackage

`default_nettype wire

@@ rtl/csl_chan_if.sv @@
// Channel interfaces of the circular sequence list: the operation input and
// the result output, each with valid, ready and payload.
// Depends on csl_pkg for the field widths.
`default_nettype none

interface csl_in_if import csl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [VAL_W-1:0]  value;
  logic signed [VAL_W-1:0]  key;

  modport source(output valid, func, value, key, input ready);
  modport sink(input valid, func, value, key, output ready);
endinterface

interface csl_out_if import csl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [31:0]       element;
  logic [ENT_W-1:0]         entries;
  logic                     last;

  modport source(output valid, status, element, entries, last, input ready);
  modport sink(input valid, status, element, entries, last, output ready);
endinterface

`default_nettype wire

@@ rtl/csl_cell.sv @@
// One storage cell of the ring: holds one entry and loads it from either
// neighbor or keeps it, as the shared shift command says.
// Depends on csl_pkg.
`default_nettype none

module csl_cell
  import csl_pkg::*;
(
  input  wire logic             clk,
  input  wire shift_t           shift,
  input  wire logic [VAL_W-1:0] from_prev,
  input  wire logic [VAL_W-1:0] from_next,
  output logic      [VAL_W-1:0] q
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  always_comb begin
    case (shift)
      SH_LEFT:  data_nxt = from_next;
      SH_RIGHT: data_nxt = from_prev;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

@@ rtl/csl_ctrl.sv @@
// Sequencer of the circular sequence list: decodes each operation, steps the
// ring one position a cycle unless a stalled output holds a read-out, edits
// the entry passing the head cell, keeps the entry count and orientation, and
// holds the output register. Depends on csl_pkg and the channel interfaces.
`default_nettype none

module csl_ctrl
  import csl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  csl_in_if.sink                in_chan,
  csl_out_if.source             out_chan,
  input  wire logic [VAL_W-1:0] tap,
  input  wire logic [VAL_W-1:0] next_l,
  input  wire logic [VAL_W-1:0] next_r,
  output ring_ctl_t             ring
);

  state_t            state_r, state_nxt;
  func_t             op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  carry_r, carry_nxt;
  logic              dir_r, dir_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic              pend_r, pend_nxt;
  logic              ins_r, ins_nxt;
  logic              del_r, del_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [31:0]       out_element_r, out_element_nxt;
  logic [ENT_W-1:0]  out_entries_r, out_entries_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              in_list;
  logic              match;
  logic              advance;
  logic              pass_end;
  logic              trig;
  logic              hit_any;
  logic              full;
  logic              empty;
  logic [VAL_W-1:0]  look;
  shift_t            shift_dir;
  func_t             in_func;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_func  = func_t'(in_chan.func);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign look     = dir_r ? next_r : next_l;
  assign shift_dir = dir_r ? SH_RIGHT : SH_LEFT;
  assign in_list  = (CNT_W'(step_r) < cnt_r);
  assign match    = in_list && (tap == key_r) && !found_r &&
                    ((op_r == F_INS_KEY) || (op_r == F_DEL_KEY));
  assign advance  = !((op_r == F_READ) && in_list && !out_free);
  assign pass_end = (state_r == ST_PASS) && advance && (step_r == IDX_W'(DEPTH - 1));
  assign hit_any  = found_r || match;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    key_nxt    = key_r;
    carry_nxt  = carry_r;
    dir_nxt    = dir_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    pend_nxt   = pend_r;
    ins_nxt    = ins_r;
    del_nxt    = del_r;
    status_nxt = status_r;
    trig       = 1'b0;
    ring.shift = SH_HOLD;
    ring.emit  = tap;
    in_chan.ready   = 1'b0;
    out_load        = 1'b0;
    out_status_nxt  = S_OK;
    out_element_nxt = '0;
    out_entries_nxt = ENT_W'(cnt_r);
    out_last_nxt    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_fire) begin
          op_nxt     = in_func;
          val_nxt    = in_chan.value;
          key_nxt    = in_chan.key;
          step_nxt   = '0;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          ins_nxt    = 1'b0;
          del_nxt    = 1'b0;
          status_nxt = S_OK;
          state_nxt  = ST_PASS;
          if (in_func inside {F_APPEND, F_INS_FRONT, F_INS_KEY}) begin
            if (full) begin
              status_nxt = S_FULL;
              state_nxt  = ST_RESP;
            end else if (in_func == F_INS_KEY && empty) begin
              op_nxt = F_INS_FRONT;
            end else if (in_func == F_APPEND) begin
              pos_nxt = IDX_W'(cnt_r);
            end
          end else if (empty) begin
            status_nxt = S_EMPTY;
            state_nxt  = ST_RESP;
          end else if (in_func == F_REVERSE) begin
            state_nxt = (cnt_r == CNT_W'(1)) ? ST_RESP : ST_ROT;
          end else if (in_func == F_DEL_END) begin
            pos_nxt = IDX_W'(cnt_r - CNT_W'(1));
          end
        end
      end

      ST_PASS: begin
        if (advance) begin
          ring.shift = shift_dir;
          step_nxt   = step_r + IDX_W'(1);
          found_nxt  = hit_any;
          case (op_r)
            F_APPEND, F_INS_FRONT, F_INS_KEY: begin
              trig     = (op_r == F_INS_KEY) ? pend_r : (step_r == pos_r);
              pend_nxt = match;
              if (ins_r) begin
                ring.emit = carry_r;
                carry_nxt = tap;
              end else if (trig) begin
                ring.emit = val_r;
                carry_nxt = tap;
                ins_nxt   = 1'b1;
              end
            end
            F_DEL_FRONT, F_DEL_END, F_DEL_KEY: begin
              trig    = (op_r == F_DEL_KEY) ? match : (step_r == pos_r);
              del_nxt = del_r || trig;
              if (del_r || trig) begin
                ring.emit = look;
              end
            end
            F_READ: begin
              if (in_list) begin
                out_load        = 1'b1;
                out_element_nxt = 32'(tap);
                out_last_nxt    = (CNT_W'(step_r) == cnt_r - CNT_W'(1));
              end
            end
            default: ring.emit = tap;
          endcase
          if (pass_end) begin
            step_nxt  = '0;
            state_nxt = (op_r == F_READ) ? ST_IDLE : ST_RESP;
            case (op_r)
              F_APPEND, F_INS_FRONT: cnt_nxt = cnt_r + CNT_W'(1);
              F_DEL_FRONT, F_DEL_END: cnt_nxt = cnt_r - CNT_W'(1);
              F_INS_KEY: begin
                if (hit_any) begin
                  cnt_nxt = cnt_r + CNT_W'(1);
                end else begin
                  status_nxt = S_NOT_FOUND;
                end
              end
              F_DEL_KEY: begin
                if (hit_any) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end else begin
                  status_nxt = S_NOT_FOUND;
                end
              end
              default: cnt_nxt = cnt_r;
            endcase
          end
        end
      end

      ST_ROT: begin
        ring.shift = shift_dir;
        step_nxt   = step_r + IDX_W'(1);
        if (CNT_W'(step_r) == cnt_r - CNT_W'(2)) begin
          step_nxt  = '0;
          dir_nxt   = !dir_r;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dir_r       <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      ins_r       <= 1'b0;
      del_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      ins_r       <= ins_nxt;
      del_r       <= del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    key_r    <= key_nxt;
    carry_r  <= carry_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r  <= out_status_nxt;
      out_element_r <= out_element_nxt;
      out_entries_r <= out_entries_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.element = out_element_r;
  assign out_chan.entries = out_entries_r;
  assign out_chan.last    = out_last_r;

  // The list never holds more entries than there are cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // The entry count only moves at the end of an editing pass.
  a_cnt_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_PASS) |=> $stable(cnt_r))
    else $error("entry count changed outside a pass");

  // Every pass other than a read-out is answered by one status transaction.
  a_pass_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_end && op_r != F_READ) |=> (state_r == ST_RESP))
    else $error("pass ended without a status transaction");

  // An insert and a delete never act in the same pass.
  a_edit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ins_r && del_r))
    else $error("insert and delete both active");

endmodule

`default_nettype wire

@@ rtl/circular_sequence_list.sv @@
// Top level of the circular sequence list: a ring of storage cells driven by
// the sequencer, with the operation and result channels.
// Depends on csl_pkg, csl_chan_if, csl_cell and csl_ctrl.
//
//   channel   direction  handshake      payload
//   in_chan   input      valid/ready    func, value, key
//   out_chan  output     valid/ready    status, element, entries, last
//
// In an editing operation and in a read-out of a non-empty list the ring turns
// once past the head cell, one step per cycle unless a stalled output holds it.
// Reverse turns the ring and flips the orientation; refused or empty-list operations
// go straight to the response. Reset clears count and orientation.
// A new transaction is taken while the last result still waits on out_chan.
`default_nettype none

module circular_sequence_list
  import csl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  csl_in_if.sink    in_chan,
  csl_out_if.source out_chan
);

  ring_ctl_t        ring;
  logic [VAL_W-1:0] q [DEPTH];

  csl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .tap      (q[0]),
    .next_l   (q[1]),
    .next_r   (q[DEPTH-1]),
    .ring     (ring)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] from_prev;
    logic [VAL_W-1:0] from_next;

    if (i == 0) begin : g_first
      assign from_prev = q[DEPTH-1];
    end else if (i == 1) begin : g_second
      assign from_prev = ring.emit;
    end else begin : g_mid
      assign from_prev = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign from_next = ring.emit;
    end else begin : g_inner
      assign from_next = q[i+1];
    end

    csl_cell u_cell (
      .clk       (clk),
      .shift     (ring.shift),
      .from_prev (from_prev),
      .from_next (from_next),
      .q         (q[i])
    );
  end

endmodule

`default_nettype wire
